// ----- hw/rtl/ulec_pkg.sv -----
package ulec_pkg;

    // line buffer geometry
    localparam int unsigned LINE_CAPACITY = 64;
    localparam int unsigned ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int unsigned CNT_W         = 7;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_CAPACITY);

    // line terminators
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_TX   = 2'd1,
        MODE_WAIT = 2'd2
    } t_mode;

    // store access issued by the control stage
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // result fields known at the end of the control stage
    typedef struct packed {
        logic             valid;
        logic             tx_valid;
        t_mode            phase;
        logic             line_ready;
        logic [CNT_W-1:0] line_length;
    } t_stage;

endpackage

// ----- hw/rtl/ulec_if.sv -----
// status snapshot channel
interface ulec_in_if;
    logic       valid;
    logic       ready;
    logic       rx_ready;
    logic       rx_error;
    logic [7:0] rx_byte;
    logic       tx_empty;
    logic       tx_done;

    modport source (output valid, rx_ready, rx_error, rx_byte, tx_empty, tx_done,
                    input ready);
    modport sink   (input valid, rx_ready, rx_error, rx_byte, tx_empty, tx_done,
                    output ready);
endinterface

// echo result channel
interface ulec_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic [1:0] phase;
    logic       line_ready;
    logic [6:0] line_length;

    modport source (output valid, tx_valid, tx_char, phase, line_ready, line_length,
                    input ready);
    modport sink   (input valid, tx_valid, tx_char, phase, line_ready, line_length,
                    output ready);
endinterface

// ----- hw/rtl/ulec_store.sv -----
module ulec_store (
    input  logic              i_clk,
    input  ulec_pkg::t_mem_req i_req,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [ulec_pkg::LINE_CAPACITY];
    logic [7:0] r_rd_data;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/ulec_ctrl.sv -----
module ulec_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_rx_ready,
    input  logic               i_rx_error,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_tx_empty,
    input  logic               i_tx_done,
    input  logic               i_take,
    output ulec_pkg::t_mem_req o_req,
    output ulec_pkg::t_stage   o_stage
);

    localparam int unsigned CW = ulec_pkg::CNT_W;
    localparam int unsigned AW = ulec_pkg::ADDR_W;

    ulec_pkg::t_mode  r_mode, n_mode;
    logic [CW-1:0]    r_rcnt, n_rcnt;
    logic [CW-1:0]    r_scnt, n_scnt;
    logic [CW-1:0]    r_pos, n_pos;
    ulec_pkg::t_stage r_stage, n_stage;

    logic          accept;
    logic          fire;
    logic          term;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] rcnt_inc;

    // stage register frees up when empty or moving on
    assign o_ready = !r_stage.valid || i_take;
    assign accept  = i_valid && o_ready;

    assign term     = (i_rx_byte == ulec_pkg::CH_LF) || (i_rx_byte == ulec_pkg::CH_CR);
    assign pos_inc  = r_pos + CW'(1);
    assign rcnt_inc = r_rcnt + CW'(1);

    // phase sequencer and store access
    always_comb begin
        n_mode      = r_mode;
        n_rcnt      = r_rcnt;
        n_scnt      = r_scnt;
        n_pos       = r_pos;
        fire        = 1'b0;
        o_req       = '0;
        o_req.wdata = i_rx_byte;
        o_req.waddr = r_rcnt[AW-1:0];
        o_req.raddr = r_pos[AW-1:0];
        n_stage     = r_stage;
        if (i_take) begin
            n_stage.valid = 1'b0;
        end
        if (accept) begin
            n_stage.line_ready = 1'b0;
            unique case (r_mode)
                ulec_pkg::MODE_TX: begin
                    if (i_tx_empty && (r_pos < r_scnt)) begin
                        fire     = 1'b1;
                        o_req.re = 1'b1;
                        n_pos    = pos_inc;
                        if (pos_inc == r_scnt) begin
                            n_mode = ulec_pkg::MODE_WAIT;
                        end
                    end
                end
                ulec_pkg::MODE_WAIT: begin
                    if (i_tx_done) begin
                        n_rcnt = '0;
                        n_scnt = '0;
                        n_pos  = '0;
                        n_mode = ulec_pkg::MODE_RX;
                    end
                end
                default: begin
                    n_mode = ulec_pkg::MODE_RX;
                    if (i_rx_error) begin
                        n_rcnt = '0;
                    end else if (i_rx_ready && !(term && (r_rcnt == '0))) begin
                        if (r_rcnt < ulec_pkg::CNT_FULL) begin
                            o_req.we = 1'b1;
                            n_rcnt   = rcnt_inc;
                        end
                        if (term || (n_rcnt >= ulec_pkg::CNT_FULL)) begin
                            n_scnt             = n_rcnt;
                            n_pos              = '0;
                            n_mode             = ulec_pkg::MODE_TX;
                            n_stage.line_ready = 1'b1;
                        end
                    end
                end
            endcase
            n_stage.valid       = 1'b1;
            n_stage.tx_valid    = fire;
            n_stage.phase       = n_mode;
            n_stage.line_length = n_rcnt;
        end
    end

    // control state and stage register; the stage payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ulec_pkg::MODE_RX;
            r_rcnt        <= '0;
            r_scnt        <= '0;
            r_pos         <= '0;
            r_stage.valid <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_rcnt        <= n_rcnt;
            r_scnt        <= n_scnt;
            r_pos         <= n_pos;
            r_stage.valid <= n_stage.valid;
        end
        r_stage.tx_valid    <= n_stage.tx_valid;
        r_stage.phase       <= n_stage.phase;
        r_stage.line_ready  <= n_stage.line_ready;
        r_stage.line_length <= n_stage.line_length;
    end

    assign o_stage = r_stage;

endmodule

// ----- hw/rtl/uart_line_echo_controller_unit.sv -----
// Line-buffered UART echo controller.
// i_in carries one UART status snapshot per item (rx_ready, rx_error,
// rx_byte, tx_empty, tx_done); o_out returns exactly one result per item
// (tx_valid, tx_char, phase, line_ready, line_length), in order.
// Bytes of a line go into a 64-entry byte memory; a CR/LF ending a non-empty
// line or a full line switches to transmit, where each tx_empty item reads
// back the next byte. After the last byte the block waits for tx_done, then
// re-arms reception. A result goes from the control stage, with the memory
// read, to the output register, which drives o_out.
// Throughput: one item per cycle; the control state is updated in the cycle
// of acceptance, so the next item sees it with no bubble, and the store is
// written at acceptance, before any later read of the same entry.
// Stall: the output register and the control stage each hold one result, so
// an item is still taken while one result waits on o_out; with both full,
// i_in.ready drops until o_out.ready takes a result.
// Reset: synchronous, active low; returns to receive phase with empty
// counters and no results pending. The byte memory is not cleared.
module uart_line_echo_controller_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    ulec_in_if.sink    i_in,
    ulec_out_if.source o_out
);

    ulec_pkg::t_mem_req mem_req;
    ulec_pkg::t_stage   stage;
    logic [7:0]         rd_data;
    logic               out_free;
    logic               take;

    logic               r_o_valid;
    logic               r_o_tx_valid;
    logic [7:0]         r_o_tx_char;
    logic [1:0]         r_o_phase;
    logic               r_o_line_ready;
    logic [6:0]         r_o_line_length;

    assign out_free = !r_o_valid || o_out.ready;
    assign take     = stage.valid && out_free;

    // phase control and store access
    ulec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_rx_ready (i_in.rx_ready),
        .i_rx_error (i_in.rx_error),
        .i_rx_byte  (i_in.rx_byte),
        .i_tx_empty (i_in.tx_empty),
        .i_tx_done  (i_in.tx_done),
        .i_take     (take),
        .o_req      (mem_req),
        .o_stage    (stage)
    );

    // line byte memory
    ulec_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= stage.valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_tx_valid    <= stage.tx_valid;
            r_o_tx_char     <= stage.tx_valid ? rd_data : 8'h00;
            r_o_phase       <= stage.phase;
            r_o_line_ready  <= stage.line_ready;
            r_o_line_length <= stage.line_length;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.tx_valid    = r_o_tx_valid;
    assign o_out.tx_char     = r_o_tx_char;
    assign o_out.phase       = r_o_phase;
    assign o_out.line_ready  = r_o_line_ready;
    assign o_out.line_length = r_o_line_length;

endmodule

// ----- hw/rtl/ulec_checker.sv -----
module ulec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_tx_valid,
    input logic [7:0] i_tx_char,
    input logic [1:0] i_phase,
    input logic       i_line_ready,
    input logic [6:0] i_line_length
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // no byte shown when nothing is sent
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_tx_valid |-> i_tx_char == 8'h00)
        else $error("tx_char nonzero without tx_valid");

    // a completed line always enters transmit phase
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_line_ready |-> i_phase == 2'(ulec_pkg::MODE_TX) && !i_tx_valid)
        else $error("line_ready outside transmit entry");

    // line length never exceeds the buffer
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_line_length <= ulec_pkg::CNT_FULL)
        else $error("line_length beyond capacity");

    // bytes are only sent in transmit or on the move to wait
    a_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_tx_valid |-> i_phase == 2'(ulec_pkg::MODE_TX)
            || i_phase == 2'(ulec_pkg::MODE_WAIT))
        else $error("byte sent in receive phase");

endmodule

bind uart_line_echo_controller_unit ulec_checker u_ulec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_tx_valid    (o_out.tx_valid),
    .i_tx_char     (o_out.tx_char),
    .i_phase       (o_out.phase),
    .i_line_ready  (o_out.line_ready),
    .i_line_length (o_out.line_length)
);
